@@ rtl/feedback_delay_echo_macros.svh @@
// Assertion helpers for the top-level RTL file, feedback_delay_echo.sv.
`ifndef FEEDBACK_DELAY_ECHO_MACROS_SVH
`define FEEDBACK_DELAY_ECHO_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FDE_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FDE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/fde_pkg.sv @@
package fde_pkg;

  localparam int MAX_DELAY_FRAMES = 65536;
  localparam int MAX_CHANNELS     = 2;

  localparam int POS_W    = $clog2(MAX_DELAY_FRAMES);
  localparam int CH_W     = $clog2(MAX_CHANNELS);
  localparam int ADDR_W   = POS_W + CH_W;
  localparam int DEPTH    = MAX_DELAY_FRAMES * MAX_CHANNELS;
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int THR_W    = 23;
  localparam int CC_W     = 2;
  localparam int CNT_W    = 17;
  localparam int CFG_W    = 23;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT,
    REG_DELAY_FRAMES,
    REG_DRY_GAIN,
    REG_WET_GAIN,
    REG_FEEDBACK_GAIN,
    REG_SILENCE_THRESHOLD
  } cfg_reg_e;

  // Per-word bookkeeping that travels with the sample down the pipe.
  typedef struct packed {
    logic [ADDR_W-1:0] wr_addr;
    logic              last_ch;
    logic              eob;
  } tag_t;

  // Per-word update request for the tail tracker, carrying the block-end flag.
  typedef struct packed {
    logic fire;
    logic nonzero;
    logic last_ch;
    logic eob;
  } tail_ctl_t;

endpackage

@@ rtl/fde_ram.sv @@
module fde_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fde_mix.sv @@
module fde_mix (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic                           fire_i,
  input  logic signed [fde_pkg::SAMPLE_W-1:0] x_i,
  input  logic signed [fde_pkg::SAMPLE_W-1:0] d_i,
  input  fde_pkg::tag_t                  tag_i,
  input  logic [fde_pkg::GAIN_W-1:0]     dry_i,
  input  logic [fde_pkg::GAIN_W-1:0]     wet_i,
  input  logic [fde_pkg::GAIN_W-1:0]     fb_i,
  input  logic [fde_pkg::THR_W-1:0]      thr_i,
  output logic                           vb_o,
  output fde_pkg::tag_t                  tag_o,
  output logic signed [fde_pkg::SAMPLE_W-1:0] y_o,
  output logic signed [fde_pkg::SAMPLE_W-1:0] w_o
);

  import fde_pkg::*;

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FRAC_W = 15;
  localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(1 << (FRAC_W - 1));

  logic                       vb_q;
  tag_t                       tag_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [PROD_W-1:0]   p_dry_q, p_wet_q, p_fb_q;
  logic signed [PROD_W-1:0]   p_dry_d, p_wet_d, p_fb_d;
  logic signed [SUM_W-1:0]    sum_y, sum_w;
  logic signed [SAMPLE_W-1:0] w_sat;
  logic [SAMPLE_W:0]          w_mag;

  // Drop the fraction, then clamp to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] rnd_sat(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-FRAC_W-1:0] q;
    logic signed [SAMPLE_W-1:0] r;
    q = s[SUM_W-1:FRAC_W];
    if (q[SUM_W-FRAC_W-1:SAMPLE_W-1] == '0 || q[SUM_W-FRAC_W-1:SAMPLE_W-1] == '1) begin
      r = q[SAMPLE_W-1:0];
    end else if (q[SUM_W-FRAC_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign p_dry_d = x_i * $signed({1'b0, dry_i});
  assign p_wet_d = d_i * $signed({1'b0, wet_i});
  assign p_fb_d  = d_i * $signed({1'b0, fb_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (load_i) begin
      vb_q <= 1'b1;
    end else if (fire_i) begin
      vb_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tag_q   <= tag_i;
      x_q     <= x_i;
      p_dry_q <= p_dry_d;
      p_wet_q <= p_wet_d;
      p_fb_q  <= p_fb_d;
    end
  end

  assign sum_y = $signed({p_dry_q[PROD_W-1], p_dry_q})
               + $signed({p_wet_q[PROD_W-1], p_wet_q}) + RND_BIAS;
  assign sum_w = $signed({{(SUM_W-SAMPLE_W-FRAC_W){x_q[SAMPLE_W-1]}}, x_q, {FRAC_W{1'b0}}})
               + $signed({p_fb_q[PROD_W-1], p_fb_q}) + RND_BIAS;

  assign y_o   = rnd_sat(sum_y);
  assign w_sat = rnd_sat(sum_w);

  // Flush quiet feedback to exact zero so the tail can go idle.
  assign w_mag = w_sat[SAMPLE_W-1] ? -{w_sat[SAMPLE_W-1], w_sat} : {w_sat[SAMPLE_W-1], w_sat};
  assign w_o   = (w_mag < {2'b00, thr_i}) ? '0 : w_sat;

  assign vb_o  = vb_q;
  assign tag_o = tag_q;

endmodule

@@ rtl/fde_tail.sv @@
module fde_tail (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fde_pkg::tail_ctl_t        ctl_i,
  input  logic [fde_pkg::POS_W-1:0] delay_i,
  output logic                      idle_o
);

  import fde_pkg::*;

  logic             act_q, act_d;
  logic [CNT_W-1:0] bfc_q, bfc_d;
  logic [CNT_W-1:0] sfc_q, sfc_d;
  logic             idle_q, idle_d;
  logic             act_now;
  logic [CNT_W-1:0] bfc_now;
  logic [CNT_W:0]   sfc_sum;

  always_comb begin
    act_now = act_q | ctl_i.nonzero;
    bfc_now = (ctl_i.last_ch && bfc_q != COUNT_MAX) ? bfc_q + 1'b1 : bfc_q;
    sfc_sum = {1'b0, sfc_q} + {1'b0, bfc_now};
    act_d   = act_now;
    bfc_d   = bfc_now;
    sfc_d   = sfc_q;
    idle_d  = idle_q;
    if (ctl_i.eob) begin
      if (act_now) begin
        sfc_d  = '0;
        idle_d = 1'b0;
      end else begin
        sfc_d  = sfc_sum[CNT_W] ? COUNT_MAX : sfc_sum[CNT_W-1:0];
        idle_d = idle_q | (sfc_d >= {1'b0, delay_i});
      end
      act_d = 1'b0;
      bfc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      bfc_q  <= '0;
      sfc_q  <= '0;
      idle_q <= 1'b0;
    end else if (ctl_i.fire) begin
      act_q  <= act_d;
      bfc_q  <= bfc_d;
      sfc_q  <= sfc_d;
      idle_q <= idle_d;
    end
  end

  assign idle_o = idle_d;

endmodule

@@ rtl/feedback_delay_echo.sv @@
// Feedback echo over a circular frame store of 65536 frames by 2 channels.
// Words enter one per cycle unless back-pressure, a store hazard or the store
// clear holds them; a word passes from the input stage to the mix stage and then
// into the output register, and the output register lets the next word in while
// a result waits. The store has one read and one write port: a word is read when
// taken and written when it leaves for the output, so a word whose delayed slot is
// still being produced by one of the two words ahead of it (delay_frames * channels
// of 1 or 2) waits until that write lands, which slows the input for such short
// delays. After reset the store is cleared one entry per cycle, all 131072 entries,
// with in_ready_o low; register writes are taken during that time.
module feedback_delay_echo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fde_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [fde_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [fde_pkg::SAMPLE_W-1:0]  in_sample_i,
  input  logic                                 end_of_block_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fde_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic                                 idle_o
);

  import fde_pkg::*;

  `include "feedback_delay_echo_macros.svh"

  localparam logic [ADDR_W-1:0] CLR_LAST = '1;
  localparam logic [CC_W-1:0]   CC_MAX   = CC_W'(MAX_CHANNELS);

  // Registers
  logic [CC_W-1:0]   cc_q;
  logic [POS_W-1:0]  delay_q;
  logic [GAIN_W-1:0] dry_q, wet_q, fb_q;
  logic [THR_W-1:0]  thr_q;

  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  logic [POS_W-1:0]  wp_q;
  logic [CH_W-1:0]   ch_q;

  logic                       va_q;
  logic signed [SAMPLE_W-1:0] xa_q;
  tag_t                       taga_q, taga_d;

  logic                       ov_q;
  logic signed [SAMPLE_W-1:0] y_q;
  logic                       idle_q;

  // Datapath and control
  logic [CC_W-1:0]   cnt_eff;
  logic [CH_W-1:0]   ch_eff;
  logic              last_ch;
  logic [ADDR_W-1:0] rd_addr;
  logic              hazard, in_acc;
  logic              out_free, b_free, a_free, move_ab, fire_b;
  logic              vb;
  tag_t              tagb;
  logic signed [SAMPLE_W-1:0] ram_rdata, y, w;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  tail_ctl_t         tail_ctl;
  logic              idle_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q    <= CC_MAX;
      delay_q <= POS_W'(1);
      dry_q   <= GAIN_W'(32768);
      wet_q   <= '0;
      fb_q    <= '0;
      thr_q   <= THR_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_CHANNEL_COUNT:     cc_q    <= cfg_wdata_i[CC_W-1:0];
        REG_DELAY_FRAMES:      delay_q <= cfg_wdata_i[POS_W-1:0];
        REG_DRY_GAIN:          dry_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_WET_GAIN:          wet_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_FEEDBACK_GAIN:     fb_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_SILENCE_THRESHOLD: thr_q   <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sweep the store to silence once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == CLR_LAST) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (cc_q == '0) begin
      cnt_eff = CC_W'(1);
    end else if (cc_q > CC_MAX) begin
      cnt_eff = CC_MAX;
    end else begin
      cnt_eff = cc_q;
    end
  end

  // A channel position left over from a larger count restarts the frame.
  assign ch_eff  = ({1'b0, ch_q} >= cnt_eff) ? '0 : ch_q;
  assign last_ch = ({1'b0, ch_eff} == cnt_eff - 1'b1);
  assign rd_addr = {wp_q - delay_q, ch_eff};

  assign taga_d.wr_addr = {wp_q, ch_eff};
  assign taga_d.last_ch = last_ch;
  assign taga_d.eob     = end_of_block_i;

  // Hold the word while a word ahead still owes the slot it would read.
  assign hazard = (va_q && taga_q.wr_addr == rd_addr) || (vb && tagb.wr_addr == rd_addr);

  assign out_free   = !ov_q || out_ready_i;
  assign fire_b     = vb && out_free;
  assign b_free     = !vb || out_free;
  assign move_ab    = va_q && b_free;
  assign a_free     = !va_q || b_free;
  assign in_ready_o = a_free && !clr_busy_q && !hazard;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      ch_q <= '0;
    end else if (in_acc) begin
      if (last_ch) begin
        ch_q <= '0;
        wp_q <= wp_q + 1'b1;
      end else begin
        ch_q <= ch_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (in_acc) begin
      va_q <= 1'b1;
    end else if (move_ab) begin
      va_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xa_q   <= in_sample_i;
      taga_q <= taga_d;
    end
  end

  assign ram_we    = clr_busy_q || fire_b;
  assign ram_waddr = clr_busy_q ? clr_addr_q : tagb.wr_addr;
  assign ram_wdata = clr_busy_q ? '0 : w;

  fde_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  fde_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (move_ab),
    .fire_i (fire_b),
    .x_i    (xa_q),
    .d_i    (ram_rdata),
    .tag_i  (taga_q),
    .dry_i  (dry_q),
    .wet_i  (wet_q),
    .fb_i   (fb_q),
    .thr_i  (thr_q),
    .vb_o   (vb),
    .tag_o  (tagb),
    .y_o    (y),
    .w_o    (w)
  );

  assign tail_ctl.fire    = fire_b;
  assign tail_ctl.nonzero = (w != '0);
  assign tail_ctl.last_ch = tagb.last_ch;
  assign tail_ctl.eob     = tagb.eob;

  fde_tail u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (tail_ctl),
    .delay_i (delay_q),
    .idle_o  (idle_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (fire_b) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_b) begin
      y_q    <= y;
      idle_q <= idle_next;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_sample_o = y_q;
  assign idle_o       = idle_q;

  `FDE_ASSERT_NOW(a_no_accept_in_clear, clr_busy_q, !in_ready_o, "word taken during store clear")
  `FDE_ASSERT_NOW(a_distinct_slots, va_q && vb, taga_q.wr_addr != tagb.wr_addr, "two words in flight share a store slot")
  `FDE_ASSERT_NEXT(a_clear_runs_full, clr_busy_q, clr_busy_q || $past(clr_addr_q) == CLR_LAST, "store clear ended early")
  `FDE_ASSERT_NOW(a_no_write_in_clear, clr_busy_q, !vb && !va_q, "pipeline busy during store clear")

endmodule

@@ verif/feedback_delay_echo_tb.sv @@
module feedback_delay_echo_tb;
  import fde_pkg::*;

  localparam int TOTAL_WORDS = 1650;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 120;
  localparam int DIR_ROWS = 37;

  // Index values past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int SMP_MAX = 8388607;
  localparam int SMP_MIN = -8388608;

  typedef enum bit [1:0] {ROW_CFG, ROW_WORD, ROW_WORD_KNOWN} row_kind_e;
  typedef enum bit [1:0] {BLK_SILENT, BLK_TINY, BLK_LOUD} blk_kind_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                idle;
  } echo_word_t;

  typedef struct {
    row_kind_e kind;
    cfg_reg_e  reg_sel;
    int        val;
    bit        eob;
    int        exp_smp;
    bit        exp_idle;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic signed [SAMPLE_W-1:0] in_sample_i = '0;
  logic                end_of_block_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_o;
  logic                idle_o;

  feedback_delay_echo DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_sample_i    (in_sample_i),
    .end_of_block_i (end_of_block_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_sample_o   (out_sample_o),
    .idle_o         (idle_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow registers, reset values.
  bit [1:0]       sh_chans = 2'd2;
  bit [15:0]      sh_delay = 16'd1;
  bit [15:0]      sh_dry = 16'd32768;
  bit [15:0]      sh_wet = 16'd0;
  bit [15:0]      sh_fb = 16'd0;
  bit [THR_W-1:0] sh_thr = 23'd16;

  // Echo state as the block should hold it.
  bit signed [SAMPLE_W-1:0] echo_mem [DEPTH];
  bit [POS_W-1:0] wr_frame = '0;
  bit [CH_W-1:0]  ch_pos = '0;
  bit             blk_live = 1'b0;
  bit [CNT_W-1:0] blk_frames = '0;
  bit [CNT_W-1:0] quiet_frames = '0;
  bit             tail_idle = 1'b0;

  echo_word_t pending_words [$];
  int words_sent = 0;
  int words_checked = 0;
  int idle_words = 0;
  int bad_words = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int cyc_cnt = 0;
  bit tx_burst = 1'b0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // reset settings: unity dry path, no echo, threshold 16, delay 1
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, SMP_MAX, 1'b0, SMP_MAX, 1'b0},
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, SMP_MIN, 1'b1, SMP_MIN, 1'b0},
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, 0, 1'b0, 0, 1'b0},
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, 0, 1'b1, 0, 1'b1},
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, 15, 1'b0, 15, 1'b1},
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, -15, 1'b1, -15, 1'b1},
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, 16, 1'b0, 16, 1'b1},
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, 0, 1'b1, 0, 1'b0},
    // block end on the first channel closes an empty block
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, -1, 1'b1, -1, 1'b0},
    '{ROW_WORD_KNOWN, REG_CHANNEL_COUNT, 1, 1'b1, 1, 1'b1},
    // gains at and above unity, short delay, no flushing
    '{ROW_CFG, REG_DRY_GAIN, 65535, 1'b0, 0, 1'b0},
    '{ROW_CFG, REG_WET_GAIN, 32768, 1'b0, 0, 1'b0},
    '{ROW_CFG, REG_FEEDBACK_GAIN, 49152, 1'b0, 0, 1'b0},
    '{ROW_CFG, REG_DELAY_FRAMES, 2, 1'b0, 0, 1'b0},
    '{ROW_CFG, REG_SILENCE_THRESHOLD, 0, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, 4194304, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, -4194304, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, SMP_MAX, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, -3, 1'b1, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, 777, 1'b0, 0, 1'b0},
    // channel position left on channel 1 is stale under one channel
    '{ROW_CFG, REG_CHANNEL_COUNT, 1, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, SMP_MIN, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, 12345, 1'b1, 0, 1'b0},
    '{ROW_CFG, REG_CHANNEL_COUNT, 3, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, 100, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, -100, 1'b1, 0, 1'b0},
    '{ROW_CFG, REG_CHANNEL_COUNT, 0, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, 5000, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, -5000, 1'b1, 0, 1'b0},
    // zero delay reads a full lap back
    '{ROW_CFG, REG_DELAY_FRAMES, 0, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, 65536, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, -1, 1'b1, 0, 1'b0},
    '{ROW_CFG, REG_CHANNEL_COUNT, 2, 1'b0, 0, 1'b0},
    '{ROW_CFG, REG_FEEDBACK_GAIN, 0, 1'b0, 0, 1'b0},
    '{ROW_CFG, REG_SILENCE_THRESHOLD, 8388607, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, 8388606, 1'b0, 0, 1'b0},
    '{ROW_WORD, REG_CHANNEL_COUNT, SMP_MIN, 1'b1, 0, 1'b0}
  };

  function automatic longint q15_round_sat(longint acc);
    longint r;
    r = (acc + 16384) >>> 15;
    if (r > SMP_MAX) r = SMP_MAX;
    if (r < SMP_MIN) r = SMP_MIN;
    return r;
  endfunction

  function automatic echo_word_t predict_echo(logic signed [SAMPLE_W-1:0] smp, logic eob);
    int unsigned chans;
    int unsigned ch;
    int unsigned quiet_sum;
    bit [POS_W-1:0] rd_frame;
    longint x, d, y, w, mag;
    echo_word_t res;
    chans = (sh_chans == 0) ? 1 : (sh_chans > MAX_CHANNELS) ? MAX_CHANNELS : sh_chans;
    ch = (ch_pos < chans) ? ch_pos : 0;
    // delay is taken modulo the store depth in frames
    rd_frame = wr_frame - sh_delay;
    x = smp;
    d = echo_mem[int'(rd_frame) * MAX_CHANNELS + ch];
    y = q15_round_sat(x * longint'(sh_dry) + d * longint'(sh_wet));
    w = q15_round_sat(x * 32768 + d * longint'(sh_fb));
    mag = (w < 0) ? -w : w;
    if (mag < longint'(sh_thr)) w = 0;
    if (w != 0) blk_live = 1'b1;
    echo_mem[int'(wr_frame) * MAX_CHANNELS + ch] = w[SAMPLE_W-1:0];
    if (ch + 1 >= chans) begin
      ch_pos = '0;
      wr_frame++;
      if (blk_frames < COUNT_MAX) blk_frames++;
    end else begin
      ch_pos = CH_W'(ch + 1);
    end
    if (eob) begin
      if (blk_live) begin
        quiet_frames = '0;
        tail_idle = 1'b0;
      end else begin
        quiet_sum = quiet_frames + blk_frames;
        quiet_frames = (quiet_sum > COUNT_MAX) ? COUNT_MAX : CNT_W'(quiet_sum);
        if (quiet_frames >= sh_delay) tail_idle = 1'b1;
      end
      blk_live = 1'b0;
      blk_frames = '0;
    end
    res.smp = y[SAMPLE_W-1:0];
    res.idle = tail_idle;
    return res;
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (cfg_reg_e'(idx))
      REG_CHANNEL_COUNT:     sh_chans = val[1:0];
      REG_DELAY_FRAMES:      sh_delay = val[15:0];
      REG_DRY_GAIN:          sh_dry = val[15:0];
      REG_WET_GAIN:          sh_wet = val[15:0];
      REG_FEEDBACK_GAIN:     sh_fb = val[15:0];
      REG_SILENCE_THRESHOLD: sh_thr = val[THR_W-1:0];
      default: ;
    endcase
  endfunction

  // Now and then set the unused upper data bits of a narrow register.
  function automatic logic [CFG_W-1:0] pad_junk(logic [CFG_W-1:0] field, int w);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom) << w;
    return ($urandom_range(0, 3) == 0) ? (field | junk) : field;
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return CFG_W'(32768);
    if (r < 50) return CFG_W'(16'hFFFF);
    if (r < 60) return CFG_W'($urandom_range(0, 65535));
    return CFG_W'($urandom_range(0, 32768));
  endfunction

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    shadow_write(idx, val);
  endtask

  // Predict the word, then hold it on the input until it is taken.
  task automatic offer_word(logic signed [SAMPLE_W-1:0] smp, logic eob, bit known,
                            echo_word_t known_res);
    echo_word_t res;
    int gap;
    int r;
    res = predict_echo(smp, eob);
    if (known) res = known_res;
    r = $urandom_range(0, 99);
    gap = (tx_burst || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pending_words.push_back(res);
    in_valid_i <= 1'b1;
    in_sample_i <= smp;
    end_of_block_i <= eob;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Output side: check each taken word and pace out_ready_i.
  always @(posedge clk_i) begin : rx_side
    echo_word_t want;
    int r;
    rx_cycle++;
    if (out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: sample %0d idle %0b", out_sample_o, idle_o);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (idle_o === 1'b1) idle_words++;
        if (out_sample_o !== want.smp || idle_o !== want.idle) begin
          bad_words++;
          if (bad_words <= 10)
            $display("word %0d: expected sample %0d idle %0b, got sample %0d idle %0b",
                     words_checked, $signed(want.smp), want.idle, out_sample_o, idle_o);
        end
        // long hold so the pipe fills and the input backs up
        if (words_checked % 500 == 250) hold_left = HOLD_CYCLES;
      end
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (rx_cycle % 1024 < 160) begin
      out_ready_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        hold_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      end
    end
  end

  initial begin : watchdog
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    stim_row_t row;
    echo_word_t known;
    echo_word_t none;
    bit cfg_open;
    int phases;
    int phase_end;
    int chans;
    int cut;
    int r;
    blk_kind_e blk;
    logic signed [SAMPLE_W-1:0] smp;
    logic eob;
    logic [CFG_W-1:0] val;

    none = '0;
    cfg_open = 1'b0;
    phases = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) settle_idle();
        reg_write(row.reg_sel, CFG_W'(row.val));
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_we_i <= 1'b0;
        cfg_open = 1'b0;
        known.smp = SAMPLE_W'(row.exp_smp);
        known.idle = row.exp_idle;
        offer_word(SAMPLE_W'(row.val), row.eob, row.kind == ROW_WORD_KNOWN, known);
      end
    end

    while (words_sent < TOTAL_WORDS) begin
      settle_idle();
      r = $urandom_range(0, 99);
      val = (r < 45) ? 2 : (r < 80) ? 1 : $urandom_range(0, 3);
      reg_write(REG_CHANNEL_COUNT, pad_junk(val, CC_W));
      r = $urandom_range(0, 99);
      if (r < 50)      val = $urandom_range(1, 8);
      else if (r < 65) val = $urandom_range(9, 64);
      else if (r < 75) val = 0;
      else if (r < 85) val = 16'hFFFF;
      else             val = $urandom_range(0, 65535);
      reg_write(REG_DELAY_FRAMES, pad_junk(val, GAIN_W));
      reg_write(REG_DRY_GAIN, pad_junk(pick_gain(), GAIN_W));
      reg_write(REG_WET_GAIN, pad_junk(pick_gain(), GAIN_W));
      reg_write(REG_FEEDBACK_GAIN, pad_junk(pick_gain(), GAIN_W));
      r = $urandom_range(0, 99);
      if (r < 25)      val = 0;
      else if (r < 35) val = CFG_W'(SMP_MAX);
      else if (r < 75) val = $urandom_range(0, 256);
      else             val = CFG_W'($urandom);
      reg_write(REG_SILENCE_THRESHOLD, val);
      if ($urandom_range(0, 2) == 0)
        reg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
      cfg_we_i <= 1'b0;
      tx_burst = ($urandom_range(0, 3) == 0);
      phase_end = words_sent + $urandom_range(60, 160);

      while (words_sent < phase_end) begin
        chans = (sh_chans == 0) ? 1 : (sh_chans > MAX_CHANNELS) ? MAX_CHANNELS : sh_chans;
        r = $urandom_range(0, 99);
        blk = (r < 35) ? BLK_SILENT : (r < 50) ? BLK_TINY : BLK_LOUD;
        cut = $urandom_range(1, 12) * chans;
        // broken block: end it early, possibly mid-frame
        if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, cut);
        for (int k = 1; k <= cut; k++) begin
          r = $urandom_range(0, 99);
          case (blk)
            BLK_SILENT: smp = '0;
            BLK_TINY:   smp = SAMPLE_W'(int'($urandom_range(0, 62)) - 31);
            default:    smp = (r < 10) ? SAMPLE_W'(SMP_MAX) : (r < 20) ? SAMPLE_W'(SMP_MIN)
                                      : SAMPLE_W'($urandom);
          endcase
          eob = (k == cut);
          if ($urandom_range(0, 49) == 0) eob = ~eob;
          offer_word(smp, eob, 1'b0, none);
        end
      end
      phases++;
    end

    settle_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run covered %0d words over %0d random register settings plus directed cases",
             words_checked, phases);
    $display("%0d words came back with the tail flagged idle", idle_words);
    if (bad_words == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatching words", bad_words);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
